// ----- rtl/cdtp_pkg.sv -----
// Shared types, constants and ROM contents for the degree cosine unit.
package cdtp_pkg;

  localparam int unsigned HALF_TURN_DEGREES = 180;
  localparam int unsigned FULL_TURN = 2 * HALF_TURN_DEGREES;
  localparam int unsigned QUARTER_TURN = HALF_TURN_DEGREES / 2;
  localparam int unsigned EIGHTH_TURN = HALF_TURN_DEGREES / 4;
  localparam int DEG_W = $clog2(HALF_TURN_DEGREES);
  localparam int REM_W = $clog2(2 * FULL_TURN);

  localparam int ANGLE_W = 32;
  localparam int OUT_W = 16;
  localparam int Q = 30;
  localparam int unsigned TAYLOR_TERMS = 14;
  localparam int unsigned DEG_TO_RAD = 18740330;

  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W = 28;
  localparam logic [RECIP_W-1:0] MOD_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(FULL_TURN));

  localparam int TW = 25;
  localparam int T2W = 19;
  localparam int T3W = 13;
  localparam int T4W = 7;
  localparam int CRW = Q + 1;
  localparam int ROM_W = 32;

  localparam int D24_IN_W = 8;
  localparam int D24_W = 3;
  localparam int D24_SHIFT = 16;
  localparam logic [11:0] D24_RECIP = 12'd2731;
  localparam logic [D24_IN_W-1:0] D24_BIAS = 8'd12;

  localparam int D6_IN_W = 14;
  localparam int D6_W = 10;
  localparam int D6_SHIFT = 18;
  localparam logic [15:0] D6_RECIP = 16'd43691;
  localparam logic [D6_IN_W-1:0] D6_BIAS = 14'd3;

  localparam logic signed [31:0] OUT_MAX = 32'sd32767;
  localparam logic signed [31:0] OUT_MIN = -32'sd32768;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic signed [ROM_W-1:0] c;
    logic signed [ROM_W-1:0] s;
  } rom_word_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } taylor_t;

  function automatic taylor_t taylor(logic [63:0] th);
    logic [63:0] term;
    logic signed [63:0] cs;
    logic signed [63:0] sn;
    taylor_t r;
    term = 64'd1 << Q;
    cs = signed'(64'd1 << Q);
    sn = '0;
    for (int unsigned k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * th) >> Q) / 64'(k);
      unique case (2'(k))
        2'd1: sn = sn + signed'(term);
        2'd2: cs = cs - signed'(term);
        2'd3: sn = sn - signed'(term);
        2'd0: cs = cs + signed'(term);
      endcase
    end
    r.c = cs;
    r.s = sn;
    return r;
  endfunction

  function automatic rom_word_t rom_entry(int unsigned n);
    int unsigned m;
    logic negc;
    taylor_t r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    rom_word_t w;
    m = n % HALF_TURN_DEGREES;
    negc = 1'b0;
    if (m > QUARTER_TURN) begin
      m = HALF_TURN_DEGREES - m;
      negc = 1'b1;
    end
    if (m <= EIGHTH_TURN) begin
      r = taylor(64'(m) * 64'(DEG_TO_RAD));
      a = r.c;
      b = r.s;
    end else begin
      r = taylor(64'(QUARTER_TURN - m) * 64'(DEG_TO_RAD));
      a = r.s;
      b = r.c;
    end
    w.c = negc ? ROM_W'(-a) : ROM_W'(a);
    w.s = ROM_W'(b);
    return w;
  endfunction

endpackage

// ----- rtl/cdtp_front.sv -----
// Front end: magnitude, reduction to a whole turn and fold into a half turn.
module cdtp_front #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic signed [cdtp_pkg::ANGLE_W-1:0]        angle_deg,
  input  logic                                       angle_valid,
  output logic                                       angle_stall,
  input  cdtp_pkg::q_status_t                        qstat,
  output logic                                       push,
  output logic [cdtp_pkg::DEG_W+ANGLE_FRAC_BITS:0]   wdata
);

  localparam int DW = cdtp_pkg::ANGLE_W - ANGLE_FRAC_BITS;
  localparam int QTW = DW + cdtp_pkg::RECIP_W - cdtp_pkg::RECIP_SHIFT;
  localparam int RW = cdtp_pkg::REM_W;
  localparam logic [RW-1:0] FULL_R = RW'(cdtp_pkg::FULL_TURN);
  localparam logic [RW-1:0] HALF_R = RW'(cdtp_pkg::HALF_TURN_DEGREES);

  logic                           f_en;
  logic                           f1_valid;
  logic                           f2_valid;
  logic                           f3_valid;
  logic [cdtp_pkg::ANGLE_W-1:0]   f1_mag;
  logic [QTW-1:0]                 f2_quot;
  logic [RW-1:0]                  f2_xlo;
  logic [ANGLE_FRAC_BITS-1:0]     f2_frac;
  logic [RW-1:0]                  f3_rem;
  logic [ANGLE_FRAC_BITS-1:0]     f3_frac;
  logic [DW+cdtp_pkg::RECIP_W-1:0] mprod;
  logic [RW-1:0]                  r1;
  logic [RW-1:0]                  rd;
  logic                           fold;

  assign f_en = !(f3_valid && qstat.full);
  assign angle_stall = !f_en;
  assign push = f3_valid && !qstat.full;

  assign mprod = f1_mag[cdtp_pkg::ANGLE_W-1:ANGLE_FRAC_BITS] * cdtp_pkg::MOD_RECIP;

  always_comb begin
    r1 = (f3_rem >= FULL_R) ? f3_rem - FULL_R : f3_rem;
    fold = (r1 >= HALF_R);
    rd = fold ? r1 - HALF_R : r1;
    wdata = {rd[cdtp_pkg::DEG_W-1:0], fold, f3_frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (f_en) begin
      f1_valid <= angle_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f1_mag <= angle_deg[cdtp_pkg::ANGLE_W-1] ? unsigned'(-angle_deg) : unsigned'(angle_deg);
      f2_quot <= mprod[cdtp_pkg::RECIP_SHIFT +: QTW];
      f2_xlo <= f1_mag[ANGLE_FRAC_BITS +: RW];
      f2_frac <= f1_mag[ANGLE_FRAC_BITS-1:0];
      f3_rem <= f2_xlo - RW'(RW'(f2_quot) * FULL_R);
      f3_frac <= f2_frac;
    end
  end

endmodule

// ----- rtl/cdtp_queue.sv -----
// Short queue of classified words between the front and back ends.
module cdtp_queue #(
  parameter int WIDTH = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output cdtp_pkg::q_status_t qstat
);

  localparam int PW = $clog2(cdtp_pkg::QUEUE_DEPTH);
  localparam int CW = PW + 1;

  logic [WIDTH-1:0] mem [cdtp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign rdata = mem[rptr];
  assign qstat.full = (count == CW'(cdtp_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/cdtp_back.sv -----
// Back end: ROM lookup, fraction polynomials, angle-sum combine and rounding.
module cdtp_back #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int RESULT_FRAC_BITS = 14
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [cdtp_pkg::DEG_W+ANGLE_FRAC_BITS:0]  rdata,
  input  cdtp_pkg::q_status_t                       qstat,
  output logic                                      pop,
  output logic signed [cdtp_pkg::OUT_W-1:0]         cosine,
  output logic                                      cosine_valid,
  input  logic                                      cosine_stall
);

  localparam int AFB = ANGLE_FRAC_BITS;
  localparam int NSTAGE = 11;
  localparam int Q = cdtp_pkg::Q;
  localparam int TW = cdtp_pkg::TW;
  localparam int T2W = cdtp_pkg::T2W;
  localparam int T3W = cdtp_pkg::T3W;
  localparam int T4W = cdtp_pkg::T4W;
  localparam int RW = cdtp_pkg::ROM_W;
  localparam int SH = 2 * Q - RESULT_FRAC_BITS;
  localparam int QW = RESULT_FRAC_BITS + 1;
  localparam logic [63:0] ONE_OUT = 64'd1 << RESULT_FRAC_BITS;

  cdtp_pkg::rom_word_t rom [cdtp_pkg::HALF_TURN_DEGREES];

  for (genvar i = 0; i < cdtp_pkg::HALF_TURN_DEGREES; i++) begin : g_rom
    assign rom[i] = cdtp_pkg::rom_entry(i);
  end

  logic                         b_en;
  logic [NSTAGE-1:0]            bvalid;

  logic [cdtp_pkg::DEG_W-1:0]   s1_deg;
  logic                         s1_fold;
  logic [AFB-1:0]               s1_frac;

  logic [TW-1:0]                s2_t;
  logic signed [RW-1:0]         s2_cn;
  logic signed [RW-1:0]         s2_sn;
  logic                         s2_fold;

  logic [TW-1:0]                s3_t;
  logic [T2W-1:0]               s3_t2;
  logic signed [RW-1:0]         s3_cn;
  logic signed [RW-1:0]         s3_sn;
  logic                         s3_fold;

  logic [TW-1:0]                s4_t;
  logic [T2W-1:0]               s4_t2;
  logic [T3W-1:0]               s4_t3;
  logic [T4W-1:0]               s4_t4;
  logic signed [RW-1:0]         s4_cn;
  logic signed [RW-1:0]         s4_sn;
  logic                         s4_fold;

  logic [TW-1:0]                s5_t;
  logic [T2W-1:0]               s5_t2;
  logic [cdtp_pkg::D24_W-1:0]   s5_d24;
  logic [cdtp_pkg::D6_W-1:0]    s5_d6;
  logic signed [RW-1:0]         s5_cn;
  logic signed [RW-1:0]         s5_sn;
  logic                         s5_fold;

  logic [cdtp_pkg::CRW-1:0]     s6_cr;
  logic [TW-1:0]                s6_sr;
  logic signed [RW-1:0]         s6_cn;
  logic signed [RW-1:0]         s6_sn;
  logic                         s6_fold;

  logic signed [63:0]           s7_p1;
  logic signed [RW+TW:0]        s7_p2;
  logic                         s7_fold;

  logic signed [63:0]           s8_acc;
  logic                         s8_fold;

  logic [63:0]                  s9_mag;
  logic                         s9_neg;

  logic [QW-1:0]                s10_q;
  logic                         s10_neg;

  logic [AFB+TW-1:0]            tp;
  logic [2*TW-1:0]              sq;
  logic [T2W+TW-1:0]            p3;
  logic [2*T2W-1:0]             p4;
  logic [cdtp_pkg::D24_IN_W-1:0] x24;
  logic [cdtp_pkg::D24_IN_W+11:0] m24;
  logic [cdtp_pkg::D6_IN_W-1:0] x6;
  logic [cdtp_pkg::D6_IN_W+15:0] m6;
  logic signed [63:0]           p1;
  logic signed [RW+TW:0]        p2;
  logic [63:0]                  rnd;
  logic [63:0]                  qfull;
  logic signed [31:0]           res;
  logic signed [cdtp_pkg::OUT_W-1:0] cos_next;

  assign b_en = !(cosine_valid && cosine_stall);
  assign pop = b_en && !qstat.empty;
  assign cosine_valid = bvalid[NSTAGE-1];

  always_comb begin
    tp = s1_frac * TW'(cdtp_pkg::DEG_TO_RAD) + ((AFB + TW)'(1) << (AFB - 1));
    sq = s2_t * s2_t + ((2 * TW)'(1) << (Q - 1));
    p3 = s3_t2 * s3_t + ((T2W + TW)'(1) << (Q - 1));
    p4 = s3_t2 * s3_t2 + ((2 * T2W)'(1) << (Q - 1));
    x24 = cdtp_pkg::D24_IN_W'(s4_t4) + cdtp_pkg::D24_BIAS;
    m24 = x24 * cdtp_pkg::D24_RECIP;
    x6 = cdtp_pkg::D6_IN_W'(s4_t3) + cdtp_pkg::D6_BIAS;
    m6 = x6 * cdtp_pkg::D6_RECIP;
    p1 = s6_cn * signed'({1'b0, s6_cr});
    p2 = s6_sn * signed'({1'b0, s6_sr});
    rnd = s9_mag + (64'd1 << (SH - 1));
    qfull = rnd >> SH;
    res = s10_neg ? -signed'(32'(s10_q)) : signed'(32'(s10_q));
    priority if (res > cdtp_pkg::OUT_MAX) begin
      cos_next = cdtp_pkg::OUT_W'(cdtp_pkg::OUT_MAX);
    end else if (res < cdtp_pkg::OUT_MIN) begin
      cos_next = cdtp_pkg::OUT_W'(cdtp_pkg::OUT_MIN);
    end else begin
      cos_next = cdtp_pkg::OUT_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0;
    end else if (b_en) begin
      bvalid <= {bvalid[NSTAGE-2:0], !qstat.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      s1_deg <= rdata[AFB+1 +: cdtp_pkg::DEG_W];
      s1_fold <= rdata[AFB];
      s1_frac <= rdata[AFB-1:0];

      s2_t <= tp[AFB +: TW];
      s2_cn <= rom[s1_deg].c;
      s2_sn <= rom[s1_deg].s;
      s2_fold <= s1_fold;

      s3_t <= s2_t;
      s3_t2 <= sq[Q +: T2W];
      s3_cn <= s2_cn;
      s3_sn <= s2_sn;
      s3_fold <= s2_fold;

      s4_t <= s3_t;
      s4_t2 <= s3_t2;
      s4_t3 <= p3[Q +: T3W];
      s4_t4 <= p4[Q +: T4W];
      s4_cn <= s3_cn;
      s4_sn <= s3_sn;
      s4_fold <= s3_fold;

      s5_t <= s4_t;
      s5_t2 <= s4_t2;
      s5_d24 <= m24[cdtp_pkg::D24_SHIFT +: cdtp_pkg::D24_W];
      s5_d6 <= m6[cdtp_pkg::D6_SHIFT +: cdtp_pkg::D6_W];
      s5_cn <= s4_cn;
      s5_sn <= s4_sn;
      s5_fold <= s4_fold;

      s6_cr <= (cdtp_pkg::CRW'(1) << Q) - cdtp_pkg::CRW'(s5_t2 >> 1)
               + cdtp_pkg::CRW'(s5_d24);
      s6_sr <= s5_t - TW'(s5_d6);
      s6_cn <= s5_cn;
      s6_sn <= s5_sn;
      s6_fold <= s5_fold;

      s7_p1 <= p1;
      s7_p2 <= p2;
      s7_fold <= s6_fold;

      s8_acc <= s7_p1 - 64'(s7_p2);
      s8_fold <= s7_fold;

      s9_mag <= s8_acc[63] ? unsigned'(-s8_acc) : unsigned'(s8_acc);
      s9_neg <= s8_fold ^ s8_acc[63];

      s10_q <= (qfull > ONE_OUT) ? QW'(ONE_OUT) : qfull[QW-1:0];
      s10_neg <= s9_neg;

      cosine <= cos_next;
    end
  end

endmodule

// ----- rtl/cosine_degrees_table_poly_unit.sv -----
// Top level of the cosine unit for angles in fixed-point degrees.
// Throughput: one angle per cycle while angle_stall is low; a 4-word queue
// lets the front keep accepting while the output register holds a word
// under stall.
// Reset clears the stage valid bits and the queue pointers; no setup sweep.
module cosine_degrees_table_poly_unit #(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int RESULT_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [cdtp_pkg::ANGLE_W-1:0] angle_deg,
  input  logic                               angle_valid,
  output logic                               angle_stall,
  output logic signed [cdtp_pkg::OUT_W-1:0]  cosine,
  output logic                               cosine_valid,
  input  logic                               cosine_stall
);

  localparam int QDW = cdtp_pkg::DEG_W + ANGLE_FRAC_BITS + 1;

  cdtp_pkg::q_status_t qstat;
  logic                push;
  logic                pop;
  logic [QDW-1:0]      wdata;
  logic [QDW-1:0]      rdata;

  cdtp_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .angle_deg(angle_deg),
    .angle_valid(angle_valid),
    .angle_stall(angle_stall),
    .qstat(qstat),
    .push(push),
    .wdata(wdata)
  );

  cdtp_queue #(
    .WIDTH(QDW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(wdata),
    .pop(pop),
    .rdata(rdata),
    .qstat(qstat)
  );

  cdtp_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .rdata(rdata),
    .qstat(qstat),
    .pop(pop),
    .cosine(cosine),
    .cosine_valid(cosine_valid),
    .cosine_stall(cosine_stall)
  );

endmodule
